### design/ple_pkg.sv
// Package for the positional list engine: request codes, status codes,
// sequencer states and default sizes. Depends on nothing.
`default_nettype none

package ple_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int REQ_W = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int CNT_W = 7;
    localparam int STAT_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_INSERT     = 3'd4,
        REQ_ERASE      = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_OPEN,
        OP_CLOSE
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OPEN_RD,
        ST_OPEN_WR,
        ST_PUT,
        ST_CLOSE_RD,
        ST_CLOSE_WR,
        ST_FRONT_RD,
        ST_BACK_RD,
        ST_BACK_WAIT
    } t_state;

endpackage

`default_nettype wire

### design/ple_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the list elements; no dependencies.
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/ple_ctrl.sv
// Request decoder and shift sequencer for the positional list engine.
// Drives the element RAM one move at a time; uses ple_pkg.
`default_nettype none

module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int LW = $clog2(CAPACITY + 1),
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output logic                     o_busy,
    input  wire logic [REQ_W-1:0]    i_req_type,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic [VAL_W-1:0]    i_value,
    output logic                     o_ram_we,
    output logic      [AW-1:0]       o_ram_waddr,
    output logic      [VAL_W-1:0]    o_ram_wdata,
    output logic      [AW-1:0]       o_ram_raddr,
    input  wire logic [VAL_W-1:0]    i_ram_rdata,
    output logic                     o_valid,
    output logic      [VAL_W-1:0]    o_front_value,
    output logic      [VAL_W-1:0]    o_back_value,
    output logic      [CNT_W-1:0]    o_element_count,
    output logic                     o_is_empty,
    output logic      [STAT_W-1:0]   o_status
);

    t_state r_state, n_state;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_idx, n_idx;
    logic [LW-1:0]     r_at, n_at;
    logic [VAL_W-1:0]  r_val, n_val;
    t_status           r_stat, n_stat;
    logic [VAL_W-1:0]  r_front, n_front;
    logic [VAL_W-1:0]  r_back, n_back;
    logic              r_strobe, n_strobe;

    // Decoded request.
    t_op               d_op;
    t_status           d_stat;
    logic [LW-1:0]     d_at;
    logic [LW-1:0]     d_len;

    logic                 accept;
    logic signed [CW-1:0] pos_s;
    logic signed [CW-1:0] len_s;
    logic [CW-1:0]        pos_inc;
    logic                 full;
    logic                 empty;
    logic                 ins_bad;
    logic                 era_bad;
    logic [LW-1:0]        idx_dec;
    logic [LW-1:0]        idx_inc;
    logic [LW+CNT_W-1:0]  len_wide;

    function automatic logic [AW-1:0] idx_last();
        logic [LW-1:0] last;
        last = r_len - LW'(1);
        return last[AW-1:0];
    endfunction

    assign accept  = i_start && (r_state == ST_IDLE);
    assign pos_s   = signed'({{(CW-POS_W){i_position[POS_W-1]}}, i_position});
    assign len_s   = signed'({{(CW-LW){1'b0}}, r_len});
    assign pos_inc = CW'(pos_s + CW'(1));
    assign full    = (r_len == LW'(CAPACITY));
    assign empty   = (r_len == '0);
    assign ins_bad = (pos_s < -CW'(1)) || (pos_s >= len_s);
    assign era_bad = (pos_s < CW'(0)) || (pos_s >= len_s);
    assign idx_dec = r_idx - LW'(1);
    assign idx_inc = r_idx + LW'(1);

    always_comb begin
        d_op   = OP_NONE;
        d_stat = STAT_DONE;
        d_at   = '0;
        d_len  = r_len;
        unique case (t_req'(i_req_type))
            REQ_PUSH_BACK: begin
                if (full) begin
                    d_stat = STAT_FULL;
                end else begin
                    d_op  = OP_OPEN;
                    d_at  = r_len;
                    d_len = r_len + LW'(1);
                end
            end
            REQ_PUSH_FRONT: begin
                if (full) begin
                    d_stat = STAT_FULL;
                end else begin
                    d_op  = OP_OPEN;
                    d_len = r_len + LW'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    d_stat = STAT_IGNORED;
                end else begin
                    d_op  = OP_CLOSE;
                    d_len = r_len - LW'(1);
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    d_stat = STAT_IGNORED;
                end else begin
                    d_len = r_len - LW'(1);
                end
            end
            REQ_INSERT: begin
                if (full) begin
                    d_stat = STAT_FULL;
                end else if (ins_bad) begin
                    d_stat = STAT_IGNORED;
                end else begin
                    d_op  = OP_OPEN;
                    d_at  = pos_inc[LW-1:0];
                    d_len = r_len + LW'(1);
                end
            end
            REQ_ERASE: begin
                if (era_bad) begin
                    d_stat = STAT_IGNORED;
                end else begin
                    d_op  = OP_CLOSE;
                    d_at  = pos_s[LW-1:0];
                    d_len = r_len - LW'(1);
                end
            end
            default: begin
                d_stat = STAT_IGNORED;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (d_op)
                        OP_OPEN:  n_state = (r_len > d_at) ? ST_OPEN_RD : ST_PUT;
                        OP_CLOSE: n_state = (d_at < d_len) ? ST_CLOSE_RD : ST_FRONT_RD;
                        default:  n_state = ST_FRONT_RD;
                    endcase
                end
            end
            ST_OPEN_RD:   n_state = ST_OPEN_WR;
            ST_OPEN_WR:   n_state = (idx_dec > r_at) ? ST_OPEN_RD : ST_PUT;
            ST_PUT:       n_state = ST_FRONT_RD;
            ST_CLOSE_RD:  n_state = ST_CLOSE_WR;
            ST_CLOSE_WR:  n_state = (idx_inc < r_len) ? ST_CLOSE_RD : ST_FRONT_RD;
            ST_FRONT_RD:  n_state = (r_len == '0) ? ST_IDLE : ST_BACK_RD;
            ST_BACK_RD:   n_state = ST_BACK_WAIT;
            ST_BACK_WAIT: n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Datapath and RAM controls.
    always_comb begin
        n_len       = r_len;
        n_idx       = r_idx;
        n_at        = r_at;
        n_val       = r_val;
        n_stat      = r_stat;
        n_front     = r_front;
        n_back      = r_back;
        n_strobe    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx[AW-1:0];
        o_ram_wdata = i_ram_rdata;
        o_ram_raddr = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_len  = d_len;
                    n_at   = d_at;
                    n_val  = i_value;
                    n_stat = d_stat;
                    // Open moves run from the old end down; close moves run upward.
                    n_idx  = (d_op == OP_OPEN) ? r_len : d_at;
                end
            end
            ST_OPEN_RD: begin
                o_ram_raddr = idx_dec[AW-1:0];
            end
            ST_OPEN_WR: begin
                o_ram_we = 1'b1;
                n_idx    = idx_dec;
            end
            ST_PUT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_at[AW-1:0];
                o_ram_wdata = r_val;
            end
            ST_CLOSE_RD: begin
                o_ram_raddr = idx_inc[AW-1:0];
            end
            ST_CLOSE_WR: begin
                o_ram_we = 1'b1;
                n_idx    = idx_inc;
            end
            ST_FRONT_RD: begin
                o_ram_raddr = '0;
                if (r_len == '0) begin
                    n_front  = '0;
                    n_back   = '0;
                    n_strobe = 1'b1;
                end
            end
            ST_BACK_RD: begin
                o_ram_raddr = idx_last();
                n_front     = i_ram_rdata;
            end
            ST_BACK_WAIT: begin
                n_back   = i_ram_rdata;
                n_strobe = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_at    <= n_at;
        r_val   <= n_val;
        r_stat  <= n_stat;
        r_front <= n_front;
        r_back  <= n_back;
    end

    assign len_wide        = {{CNT_W{1'b0}}, r_len};
    assign o_busy          = (r_state != ST_IDLE);
    assign o_valid         = r_strobe;
    assign o_front_value   = r_front;
    assign o_back_value    = r_back;
    assign o_element_count = len_wide[CNT_W-1:0];
    assign o_is_empty      = (r_len == '0);
    assign o_status        = r_stat;

endmodule

`default_nettype wire

### design/positional_list_engine.sv
// Top level of the positional list engine: the sequencer and the element RAM.
// Uses ple_pkg, ple_ctrl and ple_ram.
`default_nettype none

// A request is taken at a clock edge where start is high and busy is low. Elements
// live in a RAM with one write and one registered read port, so every element that
// a push, pop, insert or erase has to move costs a read and then a write, and a
// push or insert spends one more step storing the new word. After that the front
// and back words are read back in the states FRONT_RD, BACK_RD and BACK_WAIT, or in
// FRONT_RD alone when the list ends up empty, and both words are then given as zero.
// A pop at the back or an ignored or rejected request moves nothing and only reads
// back the front and back words. The longest request is a push at the front of a
// list of 63 words, tied with an insert at position -1. The result word is on the
// outputs with o_valid high for exactly one cycle, the first cycle in which busy is
// low again, and cannot be held off by the receiver; a new request can be taken at
// the end of that same cycle.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [REQ_W-1:0]    i_req_type,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic [VAL_W-1:0]    i_value,
    output logic                     o_valid,
    output logic      [VAL_W-1:0]    o_front_value,
    output logic      [VAL_W-1:0]    o_back_value,
    output logic      [CNT_W-1:0]    o_element_count,
    output logic                     o_is_empty,
    output logic      [STAT_W-1:0]   o_status
);

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    ple_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_valid        (o_valid),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_element_count(o_element_count),
        .o_is_empty     (o_is_empty),
        .o_status       (o_status)
    );

    ple_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

endmodule

`default_nettype wire
